[rtl/spq_pkg.sv]
// Shared types and codes of the sorted priority queue.
package spq_pkg;

  localparam int VAL_W = 32;
  localparam int PRI_W = 8;
  localparam int CAP_W = 7;
  localparam int ENT_W = VAL_W + PRI_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       load;      // latch request, snapshot count into the insert cursor
    logic       wr_new;    // write the new entry at the cursor
    logic       wr_shift;  // move the entry read last one slot back, step cursor down
    logic       rd_head;   // read the head entry
    logic       rd_prev;   // read the entry in front of the cursor
    logic       out_load;  // load the result register and commit the request
    logic [1:0] status;
  } spq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pop;
    logic is_full;
    logic is_empty;
    logic cur_one;   // insert cursor at slot one
    logic pri_ge;    // entry read has priority greater or equal to the new one
    logic out_busy;  // result register holds a result not yet taken
  } spq_stat_t;

endpackage

[rtl/spq_ram.sv]
// Generic single write port, single read port RAM with registered read.
module spq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/spq_dp.sv]
// Datapath: entry RAM as a ring, count, head, insert cursor and result register.
module spq_dp import spq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  spq_cmd_t         cmd,
  output spq_stat_t        stat,
  input  logic [ENT_W-1:0] in_tdata,
  input  logic             in_tuser,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ENT_W-1:0] out_tdata,
  output logic [1:0]       out_tuser
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_A  = (AW + 1)'(DEPTH);

  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    head_r;
  logic [CW-1:0]    cur_r;
  logic             item_cmd_r;
  logic [ENT_W-1:0] item_r;
  logic             out_valid_r;
  logic [ENT_W-1:0] out_data_r;
  logic [1:0]       out_status_r;

  logic [CW-1:0]    rd_log;
  logic [AW-1:0]    wr_phys;
  logic [AW-1:0]    rd_phys;
  logic [AW:0]      wr_sum;
  logic [AW:0]      rd_sum;
  logic [AW:0]      head_inc;
  logic             wr_en;
  logic [ENT_W-1:0] wr_data;
  logic             rd_en;
  logic [ENT_W-1:0] rd_data;

  // logical slot to ring address: one add, one compare and subtract
  always_comb begin
    if (cmd.rd_head) begin
      rd_log = '0;
    end else if (cmd.wr_shift) begin
      rd_log = cur_r - CW'(2);
    end else begin
      rd_log = cur_r - CW'(1);
    end
    wr_sum  = {1'b0, head_r} + {1'b0, cur_r[AW-1:0]};
    rd_sum  = {1'b0, head_r} + {1'b0, rd_log[AW-1:0]};
    wr_phys = (wr_sum >= DEPTH_A) ? AW'(wr_sum - DEPTH_A) : wr_sum[AW-1:0];
    rd_phys = (rd_sum >= DEPTH_A) ? AW'(rd_sum - DEPTH_A) : rd_sum[AW-1:0];
    head_inc = {1'b0, head_r} + (AW + 1)'(1);
  end

  assign wr_en   = cmd.wr_new | cmd.wr_shift;
  assign wr_data = cmd.wr_shift ? rd_data : item_r;
  assign rd_en   = cmd.rd_head | cmd.rd_prev;

  spq_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_phys),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_phys),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        if (cmd.status == ST_DONE) begin
          if (item_cmd_r == CMD_POP) begin
            count_r <= count_r - CW'(1);
            head_r  <= (head_inc == DEPTH_A) ? '0 : head_inc[AW-1:0];
          end else begin
            count_r <= count_r + CW'(1);
          end
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd_r <= in_tuser;
      item_r     <= in_tdata;
      cur_r      <= count_r;
    end else if (cmd.wr_shift) begin
      cur_r <= cur_r - CW'(1);
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.status;
      out_data_r   <= (cmd.status == ST_DONE && item_cmd_r == CMD_POP) ? rd_data : '0;
    end
  end

  always_comb begin
    stat.is_pop   = (item_cmd_r == CMD_POP);
    stat.is_full  = (CMPW'(count_r) >= CMPW'(cap_r)) || (count_r >= DEPTH_C);
    stat.is_empty = (count_r == '0);
    stat.cur_one  = (cur_r == CW'(1));
    stat.pri_ge   = (rd_data[ENT_W-1:VAL_W] >= item_r[ENT_W-1:VAL_W]);
    stat.out_busy = out_valid_r & ~out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} < DEPTH_A)
    else $error("head outside ring");

  a_shift_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_shift |-> cur_r != '0)
    else $error("shift with cursor at head");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_new |-> count_r < DEPTH_C && cur_r <= count_r)
    else $error("insert without room");

endmodule

[rtl/spq_ctrl.sv]
// Controller: sequences one request at a time through the datapath.
module spq_ctrl import spq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_WNEW   = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [1:0] status_r;
  logic [1:0] status_nxt;

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    in_tready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        status_nxt = ST_DONE;
        state_nxt  = S_RESP;
        if (stat.is_pop) begin
          if (stat.is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            cmd.rd_head = 1'b1;
          end
        end else if (stat.is_full) begin
          status_nxt = ST_FULL;
        end else if (stat.is_empty) begin
          cmd.wr_new = 1'b1;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        // stop behind the first entry of greater or equal priority
        if (stat.pri_ge) begin
          cmd.wr_new = 1'b1;
          state_nxt  = S_RESP;
        end else begin
          cmd.wr_shift = 1'b1;
          if (stat.cur_one) begin
            state_nxt = S_WNEW;
          end else begin
            cmd.rd_prev = 1'b1;
          end
        end
      end
      S_WNEW: begin
        cmd.wr_new = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        // hold until the result register is free
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_DONE;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  a_one_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_new && cmd.wr_shift))
    else $error("two RAM writes in one cycle");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_DECIDE)
    else $error("request taken outside idle");

  a_resp_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> in_tready)
    else $error("controller not back to idle after result");

endmodule

[rtl/sorted_priority_queue.sv]
// Top level of the sorted priority queue: controller, datapath and entry RAM.
//
//  channel  dir  handshake          payload
//  in_      in   tvalid / tready    tuser: cmd; tdata: value, priority_req
//  out_     out  tvalid / tready    tuser: status; tdata: out_value, out_priority
//  cfg_     in   wr_en              wr_data: capacity
//
// Pop, refused push and refused pop go from idle through decide to respond; a push into
// a non-empty queue also compares, moving each entry of lower priority back one slot.
// The single read and single write port of the entry RAM set the push cost.
// rst_n is synchronous; after reset the queue is empty and capacity is 64, and the
// RAM needs no clearing. A stalled result holds the controller before it returns to idle.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [ENT_W-1:0] in_tdata,    // [31:0] value, [39:32] priority_req
  input  logic             in_tuser,    // [0] cmd
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ENT_W-1:0] out_tdata,   // [31:0] out_value, [39:32] out_priority
  output logic [1:0]       out_tuser,   // [1:0] status
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

[verif/spq_checker.sv]
// Checker of the sorted priority queue: watches requests and results, predicts and compares.
module spq_checker import spq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [ENT_W-1:0] in_tdata,
  input  logic             in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [ENT_W-1:0] out_tdata,
  input  logic [1:0]       out_tuser,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  output int               errors,
  output int               pending,
  output int               pushes_stored,
  output int               pushes_refused,
  output int               pops_served,
  output int               pops_refused,
  output int               peak_fill
);

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] pri;
  } spq_result_t;

  logic [VAL_W-1:0] slot_value [DEPTH];
  logic [PRI_W-1:0] slot_pri [DEPTH];
  int               fill;
  int               results_taken;
  logic [CAP_W-1:0] capacity;
  spq_result_t      results_due [$];

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    errors++;
    if (errors <= 20)
      $display("mismatch in result %0d: %s got %0h expected %0h", results_taken, what, got, want);
  endtask

  // Apply one request to the sorted array and return the result it gives.
  function automatic spq_result_t queue_request(input logic cmd, input logic [VAL_W-1:0] val,
                                                input logic [PRI_W-1:0] pri);
    spq_result_t r;
    int          room;
    int          pos;
    r    = '{status: ST_DONE, value: '0, pri: '0};
    room = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
    if (cmd == CMD_PUSH) begin
      if (fill >= room) begin
        r.status = ST_FULL;
      end else begin
        // go behind every entry of greater or equal priority
        pos = 0;
        while (pos < fill && slot_pri[pos] >= pri) pos++;
        for (int i = fill; i > pos; i--) begin
          slot_value[i] = slot_value[i-1];
          slot_pri[i]   = slot_pri[i-1];
        end
        slot_value[pos] = val;
        slot_pri[pos]   = pri;
        fill++;
      end
    end else if (fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.value = slot_value[0];
      r.pri   = slot_pri[0];
      for (int i = 1; i < fill; i++) begin
        slot_value[i-1] = slot_value[i];
        slot_pri[i-1]   = slot_pri[i];
      end
      fill--;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    spq_result_t got;
    spq_result_t due;
    if (!rst_n) begin
      fill           = 0;
      results_taken  = 0;
      capacity       = CAP_RESET;
      errors         = 0;
      pushes_stored  = 0;
      pushes_refused = 0;
      pops_served    = 0;
      pops_refused   = 0;
      peak_fill      = 0;
      results_due.delete();
    end else begin
      // compare first: a result never belongs to the request taken at the same edge
      if (out_tvalid === 1'b1 && out_tready) begin
        got = '{status: out_tuser, value: out_tdata[VAL_W-1:0], pri: out_tdata[ENT_W-1:VAL_W]};
        if (results_due.size() == 0) begin
          report_mismatch("result with no request outstanding, status",
                          VAL_W'(got.status), '0);
        end else begin
          due = results_due.pop_front();
          if (got.status !== due.status)
            report_mismatch("status", VAL_W'(got.status), VAL_W'(due.status));
          if (got.value !== due.value) report_mismatch("out_value", got.value, due.value);
          if (got.pri !== due.pri)
            report_mismatch("out_priority", VAL_W'(got.pri), VAL_W'(due.pri));
        end
        results_taken++;
      end
      if (in_tvalid && in_tready === 1'b1) begin
        due = queue_request(in_tuser, in_tdata[VAL_W-1:0], in_tdata[ENT_W-1:VAL_W]);
        results_due.push_back(due);
        case (due.status)
          ST_FULL:  pushes_refused++;
          ST_EMPTY: pops_refused++;
          default: begin
            if (in_tuser == CMD_PUSH) pushes_stored++;
            else pops_served++;
          end
        endcase
        if (fill > peak_fill) peak_fill = fill;
      end
      if (cfg_wr_en) capacity = cfg_wr_data;
    end
    pending = results_due.size();
  end

endmodule

[verif/sorted_priority_queue_tb.sv]
// Testbench top of the sorted priority queue: clock, reset, requests, capacity writes, verdict.
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH       = 64;
  localparam int QUIET_LIMIT = 1000;

  localparam int PRI_ANY    = 0;
  localparam int PRI_NARROW = 1;
  localparam int PRI_EXTREME = 2;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [ENT_W-1:0] in_tdata    = '0;
  logic             in_tuser    = 1'b0;
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  logic [ENT_W-1:0] out_tdata;
  logic [1:0]       out_tuser;
  logic             cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;

  int errors;
  int pending;
  int pushes_stored;
  int pushes_refused;
  int pops_served;
  int pops_refused;
  int peak_fill;

  bit in_gaps     = 1'b1;
  bit out_stalls  = 1'b1;
  int stall_left  = 0;
  int quiet_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  spq_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .errors        (errors),
    .pending       (pending),
    .pushes_stored (pushes_stored),
    .pushes_refused(pushes_refused),
    .pops_served   (pops_served),
    .pops_refused  (pops_refused),
    .peak_fill     (peak_fill)
  );

  // Result side: stall in random bursts while stalls are enabled.
  always @(posedge clk) begin
    if (!rst_n || !out_stalls) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending);
      $display("status: fail");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Hold the request until taken, then maybe leave a gap.
  task automatic send_request(input logic cmd, input logic [VAL_W-1:0] val,
                              input logic [PRI_W-1:0] pri);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {pri, val};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    if (in_gaps && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every result has come out.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [PRI_W-1:0] pick_priority(input int mode);
    case (mode)
      PRI_NARROW: return PRI_W'(100 + $urandom_range(3));
      PRI_EXTREME: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return '1;
          default: return PRI_W'($urandom_range(255));
        endcase
      end
      default: return PRI_W'($urandom_range(255));
    endcase
  endfunction

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n, input int push_pct,
                           input int mode);
    logic cmd;
    write_capacity(cap);
    repeat (n) begin
      cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
      send_request(cmd, $urandom, pick_priority(mode));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset state: empty queue, capacity 64
    send_request(CMD_POP, $urandom, PRI_W'($urandom));
    send_request(CMD_PUSH, 32'h7fff_ffff, 8'd0);
    send_request(CMD_PUSH, 32'h8000_0000, 8'd255);
    send_request(CMD_PUSH, 32'hffff_ffff, 8'd128);
    send_request(CMD_PUSH, 32'h0000_0000, 8'd128);
    send_request(CMD_PUSH, 32'h1234_5678, 8'd255);
    repeat (6) send_request(CMD_POP, '1, '1);

    // fill to a small capacity, then lower it below the count
    write_capacity(7'd2);
    repeat (3) send_request(CMD_PUSH, $urandom, PRI_W'($urandom));
    write_capacity(7'd1);
    send_request(CMD_PUSH, $urandom, PRI_W'($urandom));
    send_request(CMD_POP, $urandom, PRI_W'($urandom));
    send_request(CMD_PUSH, $urandom, PRI_W'($urandom));
    send_request(CMD_POP, $urandom, PRI_W'($urandom));
    send_request(CMD_PUSH, $urandom, PRI_W'($urandom));
    send_request(CMD_POP, $urandom, PRI_W'($urandom));

    // a queue that holds nothing
    write_capacity(7'd0);
    send_request(CMD_PUSH, $urandom, PRI_W'($urandom));
    send_request(CMD_POP, $urandom, PRI_W'($urandom));

    run_phase(7'd64, 150, 75, PRI_ANY);
    run_phase(7'd127, 100, 85, PRI_NARROW);
    run_phase(7'd3, 80, 50, PRI_NARROW);
    in_gaps    <= 1'b0;
    out_stalls <= 1'b0;
    run_phase(7'd0, 30, 50, PRI_EXTREME);
    in_gaps    <= 1'b1;
    out_stalls <= 1'b1;
    run_phase(7'd1, 60, 50, PRI_EXTREME);
    run_phase(7'd16, 100, 60, PRI_NARROW);
    run_phase(CAP_W'($urandom_range(1, 127)), 150, 50, PRI_ANY);
    in_gaps <= 1'b0;
    run_phase(7'd8, 80, 40, PRI_EXTREME);
    in_gaps    <= 1'b1;
    run_phase(7'd64, 120, 70, PRI_NARROW);
    // closing stretch runs at full rate on both sides
    in_gaps    <= 1'b0;
    out_stalls <= 1'b0;
    run_phase(7'd5, 100, 50, PRI_ANY);

    settle();
    repeat (4) @(posedge clk);
    $display("covered %0d requests: %0d pushes stored, %0d refused as full,",
             pushes_stored + pushes_refused + pops_served + pops_refused,
             pushes_stored, pushes_refused);
    $display("%0d pops served, %0d refused as empty", pops_served, pops_refused);
    $display("deepest fill %0d entries over capacities 0 to 127, %0d mismatches",
             peak_fill, errors);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/spq_dp.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue.sv
verif/spq_checker.sv
verif/sorted_priority_queue_tb.sv
